// ----- src/asd_pkg.sv -----
// Shared types, constants and codes for the accelerometer step detector.
package asd_pkg;

    // Default axis width and fixed field widths
    localparam int AXIS_BITS_DEF = 16;
    localparam int LEVEL_W       = 24;
    localparam int ALPHA_W       = 9;
    localparam int CFG_W         = 16;
    localparam int TIME_W        = 32;
    localparam int COUNT_W       = 32;
    localparam int CFG_IDX_W     = 2;

    // Filter weight scale (alpha is in 1/FRAC_ONE) and rounding offset
    localparam int FRAC_ONE = 256;
    localparam int FRAC_HALF = 128;

    // Register reset values
    localparam logic [ALPHA_W-1:0] ALPHA_RST    = 9'd64;
    localparam logic [CFG_W-1:0]   THRESH_RST   = 16'd9000;
    localparam logic [CFG_W-1:0]   HYST_RST     = 16'd500;
    localparam logic [CFG_W-1:0]   INTERVAL_RST = 16'd250;

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA    = 2'd0,
        CFG_THRESH   = 2'd1,
        CFG_HYST     = 2'd2,
        CFG_INTERVAL = 2'd3
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_FILT_A,
        ST_FILT_B,
        ST_UPDATE
    } state_t;

    // Configuration handed to the core
    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [CFG_W-1:0]   threshold;
        logic [CFG_W-1:0]   hyst;
        logic [CFG_W-1:0]   min_interval;
    } cfg_t;

    // One finished result
    typedef struct packed {
        logic [COUNT_W-1:0] step_total;
        logic               step_now;
        logic [LEVEL_W-1:0] level;
    } result_t;

endpackage

// ----- src/asd_core.sv -----
// Sequenced datapath: squares, bit-serial square root, low-pass filter, step decision.
module asd_core #(
    parameter int AXIS_BITS = asd_pkg::AXIS_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [AXIS_BITS-1:0]   ax,
    input  logic signed [AXIS_BITS-1:0]   ay,
    input  logic signed [AXIS_BITS-1:0]   az,
    input  logic [asd_pkg::TIME_W-1:0]    t,
    input  asd_pkg::cfg_t                 cfg,
    output logic                          idle,
    output logic                          res_valid,
    input  logic                          res_take,
    output asd_pkg::result_t              res
);

    localparam int SUM_W  = 2 * AXIS_BITS;
    localparam int ROOT_W = AXIS_BITS;
    localparam int REM_W  = ROOT_W + 3;
    localparam int MUL_W  = (AXIS_BITS > asd_pkg::LEVEL_W) ? AXIS_BITS : asd_pkg::LEVEL_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 9;
    localparam int CNT_W  = $clog2(ROOT_W) + 1;
    localparam int LVL_W  = asd_pkg::LEVEL_W;

    asd_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [ACC_W-1:0]            acc_reg, acc_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [ROOT_W-1:0]           root_reg, root_next;
    logic [LVL_W-1:0]            level_reg, level_next;
    logic                        armed_reg, armed_next;
    logic [asd_pkg::TIME_W-1:0]  last_reg, last_next;
    logic [asd_pkg::COUNT_W-1:0] count_reg, count_next;

    // Captured sample
    logic signed [AXIS_BITS-1:0] x_reg, y_reg, z_reg;
    logic [asd_pkg::TIME_W-1:0]  time_reg;

    // Shared multiplier and its operand selection
    logic signed [AXIS_BITS-1:0] axis_sel;
    logic [AXIS_BITS-1:0]        axis_abs;
    logic [asd_pkg::ALPHA_W-1:0] alpha_eff;
    logic [asd_pkg::ALPHA_W-1:0] alpha_inv;
    logic [MUL_W-1:0]            mul_a, mul_b;
    logic [PROD_W-1:0]           product;

    // Square-root step
    logic [REM_W-1:0]            rem_sh;
    logic [REM_W-1:0]            trial;
    logic                        root_ge;

    // Step decision
    logic                        lvl_over;
    logic [LVL_W-1:0]            lvl_sat;
    logic                        above;
    logic [asd_pkg::CFG_W:0]     rearm_diff;
    logic                        below;
    logic [asd_pkg::TIME_W-1:0]  elapsed;
    logic                        gap_ok;
    logic                        fire;

    // Operand selection for the shared multiplier
    always_comb
    begin
        case (cnt_reg)
            CNT_W'(0): axis_sel = x_reg;
            CNT_W'(1): axis_sel = y_reg;
            default:   axis_sel = z_reg;
        endcase
        // most negative value maps to 2^(AXIS_BITS-1), still fits unsigned
        axis_abs  = axis_sel[AXIS_BITS-1] ? $unsigned(-axis_sel) : $unsigned(axis_sel);
        alpha_eff = (cfg.alpha > asd_pkg::ALPHA_W'(asd_pkg::FRAC_ONE))
                    ? asd_pkg::ALPHA_W'(asd_pkg::FRAC_ONE) : cfg.alpha;
        alpha_inv = asd_pkg::ALPHA_W'(asd_pkg::FRAC_ONE) - alpha_eff;
        case (state_reg)
            asd_pkg::ST_SQUARE:
            begin
                mul_a = MUL_W'(axis_abs);
                mul_b = MUL_W'(axis_abs);
            end
            asd_pkg::ST_FILT_A:
            begin
                mul_a = MUL_W'(alpha_eff);
                mul_b = MUL_W'(root_reg);
            end
            asd_pkg::ST_FILT_B:
            begin
                mul_a = MUL_W'(alpha_inv);
                mul_b = MUL_W'(level_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = mul_a * mul_b;
    end

    // One root bit per cycle: bring down two radicand bits, try to subtract
    always_comb
    begin
        rem_sh  = {rem_reg[REM_W-3:0], acc_reg[SUM_W-1 -: 2]};
        trial   = REM_W'({root_reg, 2'b01});
        root_ge = (rem_sh >= trial);
    end

    // Saturated level and peak / interval checks
    always_comb
    begin
        lvl_over   = |acc_reg[ACC_W-1:LVL_W+8];
        lvl_sat    = lvl_over ? '1 : acc_reg[LVL_W+7:8];
        above      = lvl_sat > {cfg.threshold, 8'b0};
        rearm_diff = {1'b0, cfg.threshold} - {1'b0, cfg.hyst};
        // negative re-arm level never reached
        below      = !rearm_diff[asd_pkg::CFG_W] &&
                     (lvl_sat < {rearm_diff[asd_pkg::CFG_W-1:0], 8'b0});
        elapsed    = time_reg - last_reg;
        gap_ok     = elapsed > asd_pkg::TIME_W'(cfg.min_interval);
        fire       = above && !armed_reg && gap_ok;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        level_next = level_reg;
        armed_next = armed_reg;
        last_next  = last_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        case (state_reg)
            asd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = asd_pkg::ST_SQUARE;
                end
            end
            asd_pkg::ST_SQUARE:
            begin
                acc_next = acc_reg + ACC_W'(product);
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(2))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = asd_pkg::ST_ROOT;
                end
            end
            asd_pkg::ST_ROOT:
            begin
                acc_next  = acc_reg << 2;
                rem_next  = root_ge ? (rem_sh - trial) : rem_sh;
                root_next = {root_reg[ROOT_W-2:0], root_ge};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                    state_next = asd_pkg::ST_FILT_A;
            end
            asd_pkg::ST_FILT_A:
            begin
                // alpha * (mag << 8) plus rounding half
                acc_next   = ACC_W'({product, 8'b0}) + ACC_W'(asd_pkg::FRAC_HALF);
                state_next = asd_pkg::ST_FILT_B;
            end
            asd_pkg::ST_FILT_B:
            begin
                acc_next   = acc_reg + ACC_W'(product);
                state_next = asd_pkg::ST_UPDATE;
            end
            asd_pkg::ST_UPDATE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    level_next = lvl_sat;
                    armed_next = fire || (armed_reg && !below);
                    if (fire)
                    begin
                        last_next = time_reg;
                        if (count_reg != '1)
                            count_next = count_reg + asd_pkg::COUNT_W'(1);
                    end
                    state_next = asd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asd_pkg::ST_IDLE;
            end
        endcase
    end

    // Result as it will be after commit
    always_comb
    begin
        res.step_total = (fire && (count_reg != '1))
                         ? count_reg + asd_pkg::COUNT_W'(1) : count_reg;
        res.step_now   = fire;
        res.level      = lvl_sat;
        idle           = (state_reg == asd_pkg::ST_IDLE);
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asd_pkg::ST_IDLE;
            cnt_reg   <= '0;
            level_reg <= '0;
            armed_reg <= 1'b0;
            last_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            level_reg <= level_next;
            armed_reg <= armed_next;
            last_reg  <= last_next;
            count_reg <= count_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        if (start && idle)
        begin
            x_reg    <= ax;
            y_reg    <= ay;
            z_reg    <= az;
            time_reg <= t;
        end
    end

endmodule

// ----- src/accel_step_detector_unit.sv -----
// Top level of the accelerometer step detector: config registers, core, output register.
// The core takes a new input beat only while idle, so it works on one beat at a time.
// Throughput is set by the bit-serial square root over the shared multiply-accumulate
// unit (3 squares, one root bit a cycle, 2 filter terms) and by output back-pressure.
// A finished result waits in the output register while the next beat is taken.
// Reset (async, active low) restores register defaults and clears level, peak, step count.
module accel_step_detector_unit #(
    parameter int AXIS_BITS = asd_pkg::AXIS_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Config write port
    input  logic                            cfg_we,
    input  logic [asd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [asd_pkg::CFG_W-1:0]       cfg_data,
    // Input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [AXIS_BITS-1:0]     accel_x,
    input  logic signed [AXIS_BITS-1:0]     accel_y,
    input  logic signed [AXIS_BITS-1:0]     accel_z,
    input  logic [asd_pkg::TIME_W-1:0]      time_ms,
    // Output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [asd_pkg::COUNT_W-1:0]     step_total,
    output logic                            step_now,
    output logic [asd_pkg::LEVEL_W-1:0]     smoothed_level
);

    asd_pkg::cfg_t    cfg_reg, cfg_next;
    logic             out_valid_reg, out_valid_next;
    asd_pkg::result_t out_reg;

    logic             core_idle;
    logic             res_valid;
    logic             res_take;
    logic             start;
    asd_pkg::result_t res;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                asd_pkg::CFG_ALPHA:    cfg_next.alpha        = cfg_data[asd_pkg::ALPHA_W-1:0];
                asd_pkg::CFG_THRESH:   cfg_next.threshold    = cfg_data;
                asd_pkg::CFG_HYST:     cfg_next.hyst         = cfg_data;
                asd_pkg::CFG_INTERVAL: cfg_next.min_interval = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // Handshakes
    assign in_ready = core_idle;
    assign start    = in_valid && core_idle;
    assign res_take = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha        <= asd_pkg::ALPHA_RST;
            cfg_reg.threshold    <= asd_pkg::THRESH_RST;
            cfg_reg.hyst         <= asd_pkg::HYST_RST;
            cfg_reg.min_interval <= asd_pkg::INTERVAL_RST;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output beat payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
            out_reg <= res;
    end

    asd_core #(
        .AXIS_BITS (AXIS_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .ax        (accel_x),
        .ay        (accel_y),
        .az        (accel_z),
        .t         (time_ms),
        .cfg       (cfg_reg),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign out_valid      = out_valid_reg;
    assign step_total     = out_reg.step_total;
    assign step_now       = out_reg.step_now;
    assign smoothed_level = out_reg.level;

endmodule
